// ----- sv/cci_pkg.sv -----
package cci_pkg;

    // Default geometry: coordinate width and fixed-point fraction width
    localparam int COORD_WIDTH   = 14;
    localparam int FRACTION_BITS = 16;

    // Lane order in the divider row
    localparam int LANE_MX = 0;
    localparam int LANE_MY = 1;
    localparam int LANE_OX = 2;
    localparam int LANE_OY = 3;
    localparam int NUM_LANES = 4;

endpackage

// ----- sv/cci_sqrt_cell.sv -----
// One step of the restoring square root: takes the next bit pair of the
// radicand and decides one root bit.
module cci_sqrt_cell #(
    parameter int RTW    = 44,
    parameter int PW     = 56,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [RTW+2:0]    in_rem,
    input  logic [RTW-1:0]    in_root,
    input  logic [PW-1:0]     in_p,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [RTW+2:0]    out_rem,
    output logic [RTW-1:0]    out_root,
    output logic [PW-1:0]     out_p,
    output logic [SIDE_W-1:0] out_side
);

    logic [RTW+2:0] rem_sh;
    logic [RTW+2:0] trial;
    logic           ge;

    always_comb
    begin
        rem_sh = {in_rem[RTW:0], in_p[PW-1:PW-2]};
        trial  = {1'b0, in_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_rem  <= ge ? (rem_sh - trial) : rem_sh;
            out_root <= {in_root[RTW-2:0], ge};
            out_p    <= {in_p[PW-3:0], 2'b00};
            out_side <= in_side;
        end
    end

endmodule

// ----- sv/cci_div_cell.sv -----
// One quotient bit of restoring division for several lanes that share
// one divisor.
module cci_div_cell #(
    parameter int DW     = 30,
    parameter int QW     = 30,
    parameter int LANES  = 4,
    parameter int SIDE_W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [DW-1:0]              in_div,
    input  logic [LANES-1:0][DW-1:0]   in_rem,
    input  logic [LANES-1:0][QW-1:0]   in_low,
    input  logic [LANES-1:0][QW-1:0]   in_q,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [DW-1:0]              out_div,
    output logic [LANES-1:0][DW-1:0]   out_rem,
    output logic [LANES-1:0][QW-1:0]   out_low,
    output logic [LANES-1:0][QW-1:0]   out_q,
    output logic [SIDE_W-1:0]          out_side
);

    logic [LANES-1:0][DW:0]   rem_sh;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][DW-1:0] rem_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem_sh[l]   = {in_rem[l], in_low[l][QW-1]};
            ge[l]       = (rem_sh[l] >= {1'b0, in_div});
            rem_next[l] = ge[l] ? DW'(rem_sh[l] - {1'b0, in_div}) : rem_sh[l][DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_div  <= in_div;
            out_side <= in_side;
            for (int l = 0; l < LANES; l++)
            begin
                out_rem[l] <= rem_next[l];
                out_low[l] <= {in_low[l][QW-2:0], 1'b0};
                out_q[l]   <= {in_q[l][QW-2:0], ge[l]};
            end
        end
    end

endmodule

// ----- sv/circle_circle_intersection.sv -----
// Channel  | Dir | tdata (low bit up)                          | tuser
// s_axis   | in  | x1, y1, r1, x2, y2, r2, zero pad            | -
// m_axis   | out | a_x, a_y, b_x, b_y, zero pad                | intersect_res
//
// Fully pipelined: one transaction per cycle unless the output stalls.
// The row holds 2*COORD_WIDTH + FRACTION_BITS square root cells and
// COORD_WIDTH + FRACTION_BITS divider cells between the stage registers.
// rst_n clears only the valid bits. A stalled output holds the whole row;
// s_tready falls only while a result waits and m_tready is low.
module circle_circle_intersection #(
    parameter int COORD_WIDTH   = cci_pkg::COORD_WIDTH,
    parameter int FRACTION_BITS = cci_pkg::FRACTION_BITS,
    localparam int CW  = COORD_WIDTH,
    localparam int F   = FRACTION_BITS,
    localparam int SIW = ((6 * CW - 2) + 7) / 8 * 8,
    localparam int MOW = ((4 * (CW + 1)) + 7) / 8 * 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [SIW-1:0] s_tdata,  // x1, y1, r1, x2, y2, r2
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [MOW-1:0] m_tdata,  // point_a_x, point_a_y, point_b_x, point_b_y
    output logic           m_tuser   // intersect_res
);

    localparam int DXW   = CW + 1;
    localparam int SQW   = 2 * CW;
    localparam int D2W   = 2 * CW + 1;
    localparam int MNW   = 3 * CW + 1;
    localparam int PW    = 4 * CW;
    localparam int RTW   = 2 * CW + F;
    localparam int LOW_W = RTW / 2;
    localparam int HIW   = RTW - LOW_W;
    localparam int NW    = 3 * CW + F;
    localparam int QW    = CW + F;
    localparam int DW    = 2 * CW + 2;
    localparam int VW    = CW + F + 3;
    localparam int OW    = CW + 1;
    localparam int NL    = cci_pkg::NUM_LANES;
    localparam int SS_W  = 1 + 4 * DXW + 2 * MNW + D2W;
    localparam int DS_W  = 5 + 2 * DXW;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: differences and sums
    logic [CW-1:0]  in_x1, in_y1, in_x2, in_y2;
    logic [CW-2:0]  in_r1, in_r2;
    assign in_x1 = s_tdata[CW-1:0];
    assign in_y1 = s_tdata[2*CW-1:CW];
    assign in_r1 = s_tdata[3*CW-2:2*CW];
    assign in_x2 = s_tdata[4*CW-2:3*CW-1];
    assign in_y2 = s_tdata[5*CW-2:4*CW-1];
    assign in_r2 = s_tdata[6*CW-3:5*CW-1];

    logic                  s1_v_reg;
    logic signed [DXW-1:0] s1_dx_reg, s1_dy_reg, s1_sx_reg, s1_sy_reg;
    logic        [CW-1:0]  s1_rs_reg;
    logic signed [CW-1:0]  s1_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg <= $signed({in_x2[CW-1], in_x2}) - $signed({in_x1[CW-1], in_x1});
            s1_dy_reg <= $signed({in_y2[CW-1], in_y2}) - $signed({in_y1[CW-1], in_y1});
            s1_sx_reg <= $signed({in_x2[CW-1], in_x2}) + $signed({in_x1[CW-1], in_x1});
            s1_sy_reg <= $signed({in_y2[CW-1], in_y2}) + $signed({in_y1[CW-1], in_y1});
            s1_rs_reg <= {1'b0, in_r1} + {1'b0, in_r2};
            s1_rd_reg <= $signed({1'b0, in_r1}) - $signed({1'b0, in_r2});
        end
    end

    // ---------------- stage 2: squares and the radius sum-difference product
    logic signed [2*DXW-1:0] dx2_full, dy2_full;
    logic        [2*CW-1:0]  s_full;
    logic signed [2*CW-1:0]  d_full;
    logic signed [2*CW:0]    dr_full;

    always_comb
    begin
        dx2_full = s1_dx_reg * s1_dx_reg;
        dy2_full = s1_dy_reg * s1_dy_reg;
        s_full   = s1_rs_reg * s1_rs_reg;
        d_full   = s1_rd_reg * s1_rd_reg;
        dr_full  = $signed({1'b0, s1_rs_reg}) * s1_rd_reg;
    end

    logic                  s2_v_reg;
    logic        [SQW-1:0] s2_dx2_reg, s2_dy2_reg, s2_s_reg, s2_d_reg;
    logic signed [SQW-1:0] s2_dr_reg;
    logic signed [DXW-1:0] s2_dx_reg, s2_dy_reg, s2_sx_reg, s2_sy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_dx2_reg <= dx2_full[SQW-1:0];
            s2_dy2_reg <= dy2_full[SQW-1:0];
            s2_s_reg   <= s_full;
            s2_d_reg   <= d_full;
            s2_dr_reg  <= dr_full[SQW-1:0];
            s2_dx_reg  <= s1_dx_reg;
            s2_dy_reg  <= s1_dy_reg;
            s2_sx_reg  <= s1_sx_reg;
            s2_sy_reg  <= s1_sy_reg;
        end
    end

    // ---------------- stage 3: distance test, chord factors, midpoint numerators
    logic        [D2W-1:0] d2;
    logic                  ok;
    logic signed [MNW-1:0] mnx_full, mny_full;

    always_comb
    begin
        d2       = {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};
        ok       = (d2 > {1'b0, s2_d_reg}) && (d2 <= {1'b0, s2_s_reg}) && (d2 != '0);
        mnx_full = s2_dx_reg * s2_dr_reg;
        mny_full = s2_dy_reg * s2_dr_reg;
    end

    logic                  s3_v_reg, s3_ok_reg;
    logic        [SQW-1:0] s3_a_reg, s3_b_reg;
    logic        [D2W-1:0] s3_d2_reg;
    logic signed [MNW-1:0] s3_mnx_reg, s3_mny_reg;
    logic signed [DXW-1:0] s3_dx_reg, s3_dy_reg, s3_sx_reg, s3_sy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ok_reg  <= ok;
            s3_a_reg   <= ok ? SQW'({1'b0, s2_s_reg} - d2) : '0;
            s3_b_reg   <= ok ? SQW'(d2 - {1'b0, s2_d_reg}) : '0;
            s3_d2_reg  <= d2;
            s3_mnx_reg <= mnx_full;
            s3_mny_reg <= mny_full;
            s3_dx_reg  <= s2_dx_reg;
            s3_dy_reg  <= s2_dy_reg;
            s3_sx_reg  <= s2_sx_reg;
            s3_sy_reg  <= s2_sy_reg;
        end
    end

    // ---------------- stage 4: radicand
    logic                s4_v_reg;
    logic [PW-1:0]       s4_p_reg;
    logic [SS_W-1:0]     s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_p_reg    <= s3_a_reg * s3_b_reg;
            s4_side_reg <= {s3_ok_reg, s3_dx_reg, s3_dy_reg, s3_sx_reg, s3_sy_reg,
                            s3_mnx_reg, s3_mny_reg, s3_d2_reg};
        end
    end

    // ---------------- square root row
    logic              sq_v    [0:RTW];
    logic [RTW+2:0]    sq_rem  [0:RTW];
    logic [RTW-1:0]    sq_root [0:RTW];
    logic [PW-1:0]     sq_p    [0:RTW];
    logic [SS_W-1:0]   sq_side [0:RTW];

    assign sq_v[0]    = s4_v_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_p[0]    = s4_p_reg;
    assign sq_side[0] = s4_side_reg;

    for (genvar i = 0; i < RTW; i++)
    begin : g_sqrt
        cci_sqrt_cell #(
            .RTW    (RTW),
            .PW     (PW),
            .SIDE_W (SS_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (sq_v[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_p      (sq_p[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_v[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_p     (sq_p[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    logic                  r_ok;
    logic signed [DXW-1:0] r_dx, r_dy, r_sx, r_sy;
    logic signed [MNW-1:0] r_mnx, r_mny;
    logic        [D2W-1:0] r_d2;
    assign {r_ok, r_dx, r_dy, r_sx, r_sy, r_mnx, r_mny, r_d2} = sq_side[RTW];

    // ---------------- M1: magnitudes and split offset products
    logic [DXW-1:0] adx_full, ady_full;
    logic [MNW-1:0] amx_full, amy_full;

    always_comb
    begin
        adx_full = r_dx[DXW-1] ? DXW'(-r_dx) : r_dx;
        ady_full = r_dy[DXW-1] ? DXW'(-r_dy) : r_dy;
        amx_full = r_mnx[MNW-1] ? MNW'(-r_mnx) : r_mnx;
        amy_full = r_mny[MNW-1] ? MNW'(-r_mny) : r_mny;
    end

    logic                  m1_v_reg, m1_ok_reg;
    logic [CW+HIW-1:0]     m1_ox_hi_reg, m1_oy_hi_reg;
    logic [CW+LOW_W-1:0]   m1_ox_lo_reg, m1_oy_lo_reg;
    logic [MNW-2:0]        m1_amx_reg, m1_amy_reg;
    logic [3:0]            m1_sgn_reg;
    logic [D2W-1:0]        m1_d2_reg;
    logic signed [DXW-1:0] m1_sx_reg, m1_sy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_v_reg <= sq_v[RTW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_ok_reg    <= r_ok;
            // ox uses dy, oy uses dx
            m1_ox_hi_reg <= ady_full[CW-1:0] * sq_root[RTW][RTW-1:LOW_W];
            m1_ox_lo_reg <= ady_full[CW-1:0] * sq_root[RTW][LOW_W-1:0];
            m1_oy_hi_reg <= adx_full[CW-1:0] * sq_root[RTW][RTW-1:LOW_W];
            m1_oy_lo_reg <= adx_full[CW-1:0] * sq_root[RTW][LOW_W-1:0];
            m1_amx_reg   <= amx_full[MNW-2:0];
            m1_amy_reg   <= amy_full[MNW-2:0];
            m1_sgn_reg[cci_pkg::LANE_MX] <= r_mnx[MNW-1];
            m1_sgn_reg[cci_pkg::LANE_MY] <= r_mny[MNW-1];
            m1_sgn_reg[cci_pkg::LANE_OX] <= r_dy[DXW-1];
            m1_sgn_reg[cci_pkg::LANE_OY] <= r_dx[DXW-1];
            m1_d2_reg    <= r_d2;
            m1_sx_reg    <= r_sx;
            m1_sy_reg    <= r_sy;
        end
    end

    // ---------------- M2: full numerators
    logic [NL-1:0][NW-1:0] num;

    always_comb
    begin
        num[cci_pkg::LANE_MX] = NW'({m1_amx_reg, {F{1'b0}}});
        num[cci_pkg::LANE_MY] = NW'({m1_amy_reg, {F{1'b0}}});
        num[cci_pkg::LANE_OX] = NW'({m1_ox_hi_reg, {LOW_W{1'b0}}}) + NW'(m1_ox_lo_reg);
        num[cci_pkg::LANE_OY] = NW'({m1_oy_hi_reg, {LOW_W{1'b0}}}) + NW'(m1_oy_lo_reg);
    end

    logic                   m2_v_reg;
    logic [DW-1:0]          m2_div_reg;
    logic [NL-1:0][DW-1:0]  m2_rem_reg;
    logic [NL-1:0][QW-1:0]  m2_low_reg;
    logic [DS_W-1:0]        m2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            m2_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_div_reg  <= {m1_d2_reg, 1'b0};
            m2_side_reg <= {m1_ok_reg, m1_sgn_reg, m1_sx_reg, m1_sy_reg};
            for (int l = 0; l < NL; l++)
            begin
                m2_rem_reg[l] <= DW'(num[l][NW-1:QW]);
                m2_low_reg[l] <= num[l][QW-1:0];
            end
        end
    end

    // ---------------- divider row
    logic                   dv_v    [0:QW];
    logic [DW-1:0]          dv_div  [0:QW];
    logic [NL-1:0][DW-1:0]  dv_rem  [0:QW];
    logic [NL-1:0][QW-1:0]  dv_low  [0:QW];
    logic [NL-1:0][QW-1:0]  dv_q    [0:QW];
    logic [DS_W-1:0]        dv_side [0:QW];

    assign dv_v[0]    = m2_v_reg;
    assign dv_div[0]  = m2_div_reg;
    assign dv_rem[0]  = m2_rem_reg;
    assign dv_low[0]  = m2_low_reg;
    assign dv_q[0]    = '0;
    assign dv_side[0] = m2_side_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        cci_div_cell #(
            .DW     (DW),
            .QW     (QW),
            .LANES  (NL),
            .SIDE_W (DS_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv_v[i]),
            .in_div    (dv_div[i]),
            .in_rem    (dv_rem[i]),
            .in_low    (dv_low[i]),
            .in_q      (dv_q[i]),
            .in_side   (dv_side[i]),
            .out_valid (dv_v[i+1]),
            .out_div   (dv_div[i+1]),
            .out_rem   (dv_rem[i+1]),
            .out_low   (dv_low[i+1]),
            .out_q     (dv_q[i+1]),
            .out_side  (dv_side[i+1])
        );
    end

    logic                  q_ok;
    logic [3:0]            q_sgn;
    logic signed [DXW-1:0] q_sx, q_sy;
    assign {q_ok, q_sgn, q_sx, q_sy} = dv_side[QW];

    // ---------------- F1: signed midpoint and offsets
    logic signed [NL-1:0][VW-1:0] qs;
    logic signed [VW-1:0]         sxe, sye;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            qs[l] = q_sgn[l] ? VW'(-{{(VW-QW){1'b0}}, dv_q[QW][l]})
                             : {{(VW-QW){1'b0}}, dv_q[QW][l]};
        end
        sxe = {{(VW-DXW){q_sx[DXW-1]}}, q_sx};
        sye = {{(VW-DXW){q_sy[DXW-1]}}, q_sy};
    end

    logic                 f1_v_reg, f1_ok_reg;
    logic signed [VW-1:0] f1_mx_reg, f1_my_reg, f1_ox_reg, f1_oy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_v_reg <= dv_v[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_ok_reg <= q_ok;
            f1_mx_reg <= (sxe <<< (F - 1)) + qs[cci_pkg::LANE_MX];
            f1_my_reg <= (sye <<< (F - 1)) + qs[cci_pkg::LANE_MY];
            f1_ox_reg <= qs[cci_pkg::LANE_OX];
            f1_oy_reg <= qs[cci_pkg::LANE_OY];
        end
    end

    // ---------------- F2: the two points in fixed point
    logic                         f2_v_reg, f2_ok_reg;
    logic signed [3:0][VW-1:0]    f2_pt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_ok_reg    <= f1_ok_reg;
            f2_pt_reg[0] <= f1_mx_reg + f1_ox_reg;
            f2_pt_reg[1] <= f1_my_reg - f1_oy_reg;
            f2_pt_reg[2] <= f1_mx_reg - f1_ox_reg;
            f2_pt_reg[3] <= f1_my_reg + f1_oy_reg;
        end
    end

    // ---------------- output register: truncate toward zero
    logic [3:0][VW-1:0] mag;
    logic [3:0][VW-1:0] tr;
    logic [3:0][OW-1:0] pt_next;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            mag[l]     = f2_pt_reg[l][VW-1] ? VW'(-f2_pt_reg[l]) : f2_pt_reg[l];
            tr[l]      = mag[l] >> F;
            pt_next[l] = !f2_ok_reg ? '0
                       : f2_pt_reg[l][VW-1] ? OW'(-tr[l]) : tr[l][OW-1:0];
        end
    end

    logic               m_tvalid_reg;
    logic [3:0][OW-1:0] m_pt_reg;
    logic               m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_pt_reg    <= pt_next;
            m_tuser_reg <= f2_ok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = MOW'(m_pt_reg);
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- sv/cci_checker.sv -----
module cci_checker #(
    parameter int MOW = 64
) (
    input logic           clk,
    input logic           rst_n,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [MOW-1:0] m_tdata,
    input logic           m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // no intersection means all coordinates zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("nonzero points without intersection");

    // input side never blocks while the output is empty or drained
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with free output");

    // an input accepted with no stall pushes the row forward
    a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tvalid |-> m_tready)
        else $error("accepted input while output stalled");

endmodule

bind circle_circle_intersection cci_checker #(
    .MOW (MOW)
) u_cci_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
